// ===== rtl/lip_pkg.sv =====
// Shared widths, constants and the job record for the linear interpolation upsampler.
package lip_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int FACTOR_W            = 4;
   localparam int DEFAULT_MAX_FACTOR  = 8;
   localparam int DEFAULT_QUEUE_DEPTH = 2;
   localparam int DIV_STEPS           = 2;
   localparam int DIV_CYCLES          = SAMPLE_W / DIV_STEPS;
   localparam int QUO_W               = SAMPLE_W + 2;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

   // One input sample, ready for the interpolator: start point and the floor
   // quotient and remainder of (new - prev) / factor.
   typedef struct packed {
      logic [SAMPLE_W-1:0] prev;
      logic [QUO_W-1:0]    step_q;
      logic [FACTOR_W-1:0] step_r;
      logic [FACTOR_W-1:0] factor;
   } job_type;

endpackage

// ===== rtl/lip_front.sv =====
// Front end: accept a sample, divide its step by the factor, hand the job to the queue.
module lip_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lip_pkg::SAMPLE_W-1:0]  req_tdata,
   input  logic [lip_pkg::FACTOR_W-1:0]  factor,
   output logic                          job_valid,
   input  logic                          job_ready,
   output lip_pkg::job_type              job
);
   import lip_pkg::*;

   localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [SAMPLE_W-1:0] start_ff;
   logic [SAMPLE_W-1:0] quot_ff, quot_in;
   logic [FACTOR_W-1:0] rem_ff, rem_in;
   logic [FACTOR_W-1:0] factor_ff;
   logic                neg_ff;
   logic [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]   mag;
   logic [QUO_W-1:0]    qext;
   logic                accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign job_valid  = (state_ff == ST_PUSH);

   assign diff = {req_tdata[SAMPLE_W-1], req_tdata} - {prev_ff[SAMPLE_W-1], prev_ff};
   assign mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

   // Restoring division, DIV_STEPS quotient bits per cycle in ST_DIV.
   always_comb begin
      logic [FACTOR_W:0] trial;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      trial   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial   = {rem_in, quot_in[SAMPLE_W-1]};
         quot_in = {quot_in[SAMPLE_W-2:0], 1'b0};
         if (trial >= {1'b0, factor_ff}) begin
            trial      = trial - {1'b0, factor_ff};
            quot_in[0] = 1'b1;
         end
         rem_in = trial[FACTOR_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (accept) begin
            prev_ff <= req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff  <= prev_ff;
         neg_ff    <= diff[SAMPLE_W];
         quot_ff   <= mag[SAMPLE_W-1:0];
         rem_ff    <= '0;
         factor_ff <= factor;
      end else if (state_ff == ST_DIV) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   // Turn the magnitude quotient into a floor quotient with a nonnegative remainder.
   assign qext = {{(QUO_W-SAMPLE_W){1'b0}}, quot_ff};

   always_comb begin
      job.prev   = start_ff;
      job.factor = factor_ff;
      if (!neg_ff) begin
         job.step_q = qext;
         job.step_r = rem_ff;
      end else if (rem_ff == '0) begin
         job.step_q = ~qext + 1'b1;
         job.step_r = '0;
      end else begin
         job.step_q = ~qext;
         job.step_r = factor_ff - rem_ff;
      end
   end

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < factor_ff))
      else $error("divider remainder not below factor");

   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_ready) |=> (job_valid && $stable(job)))
      else $error("job changed while waiting for the queue");

endmodule

// ===== rtl/lip_queue.sv =====
// Short job queue between the front end and the interpolator.
module lip_queue #(
   parameter int DEPTH = lip_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lip_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lip_pkg::job_type pop_data
);
   import lip_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lip_back.sv =====
// Interpolator: walk the line from prev to new, one output sample per cycle while rsp_tready allows.
module lip_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  lip_pkg::job_type              job,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lip_pkg::SAMPLE_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);
   import lip_pkg::*;

   logic                busy_ff;
   job_type             job_ff;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [FACTOR_W-1:0] rm_ff, rm_in;
   logic [FACTOR_W-1:0] k_ff;
   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] out_data_ff;
   logic                out_last_ff;
   logic [FACTOR_W:0]   sum;
   logic                wrap;
   logic [QUO_W-1:0]    val;
   logic                last;
   logic                advance;
   logic                load;

   assign job_ready = !busy_ff;
   assign load      = job_valid && job_ready;
   assign advance   = busy_ff && (!out_valid_ff || rsp_tready);

   // Floor quotient and remainder of the running numerator, stepped by the floor step.
   assign sum    = {1'b0, rm_ff} + {1'b0, job_ff.step_r};
   assign wrap   = (sum >= {1'b0, job_ff.factor});
   assign rm_in  = wrap ? FACTOR_W'(sum - {1'b0, job_ff.factor}) : sum[FACTOR_W-1:0];
   assign quo_in = quo_ff + job_ff.step_q + {{(QUO_W-1){1'b0}}, wrap};
   // Truncate toward zero: a negative floor with a remainder rounds up by one.
   assign val    = (quo_in[QUO_W-1] && (rm_in != '0)) ? quo_in + 1'b1 : quo_in;
   assign last   = (k_ff == job_ff.factor - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (advance && last) begin
            busy_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
         quo_ff <= {{(QUO_W-SAMPLE_W){job.prev[SAMPLE_W-1]}}, job.prev};
         rm_ff  <= '0;
         k_ff   <= '0;
      end else if (advance) begin
         quo_ff <= quo_in;
         rm_ff  <= rm_in;
         k_ff   <= k_ff + 1'b1;
      end
      if (advance) begin
         out_data_ff <= val[SAMPLE_W-1:0];
         out_last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_rm_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rm_ff < job_ff.factor))
      else $error("interpolator remainder not below factor");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff < job_ff.factor))
      else $error("output index ran past the factor");

endmodule

// ===== rtl/linear_interp_upsampler.sv =====
// Top level of the linear interpolation integer upsampler.
//
// Takes one signed 16-bit sample per req_ transaction and returns R samples on
// rsp_, where R is the upsample factor (csr_wr_data; zero acts as 1, values above
// MAX_FACTOR act as MAX_FACTOR). Output k of a run is prev + k/R of the step to
// the new sample, truncated toward zero; the last output of a run equals the new
// sample and carries rsp_tlast. The previous sample starts at 0 after reset.
// The front end accepts a sample in ST_IDLE, divides its step in ST_DIV at two
// quotient bits a cycle, and hands the job to the queue in ST_PUSH; it takes no
// new sample until that handoff. The interpolator loads a job, then emits one
// output per cycle while rsp_tready stays high, and takes the next job only after
// the last output of its run. The job queue lets the front end divide the next
// step while the interpolator still emits the current run. Write the factor only
// while the block is idle.
module linear_interp_upsampler #(
   parameter int MAX_FACTOR  = lip_pkg::DEFAULT_MAX_FACTOR,
   parameter int QUEUE_DEPTH = lip_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // config register: upsample_factor
   input  logic                          csr_wr_en,
   input  logic [lip_pkg::FACTOR_W-1:0]  csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: [15:0] in_sample
   input  logic [lip_pkg::SAMPLE_W-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: [15:0] out_sample
   output logic [lip_pkg::SAMPLE_W-1:0]  rsp_tdata,
   // tlast: run_last
   output logic                          rsp_tlast
);
   import lip_pkg::*;

   logic [FACTOR_W-1:0] factor_ff;
   logic [FACTOR_W-1:0] factor_eff;
   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   job_type             push_job, pop_job;

   // Hold the factor register.
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_wr_en) begin
         factor_ff <= csr_wr_data;
      end
   end

   // Map zero to one and clamp to MAX_FACTOR.
   always_comb begin
      if (factor_ff == '0) begin
         factor_eff = FACTOR_W'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         factor_eff = FACTOR_W'(MAX_FACTOR);
      end else begin
         factor_eff = factor_ff;
      end
   end

   lip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .factor     (factor_eff),
      .job_valid  (push_valid),
      .job_ready  (push_ready),
      .job        (push_job)
   );

   lip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_job)
   );

   lip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
